>>> design/ils_pkg.sv
// ----------------------------------------------------------------------------
// ils_pkg: shared types and constants for the indexed list store
// Command codes broadcast to the cell row and the tap grouping constant.
// ----------------------------------------------------------------------------
package ils_pkg;

	localparam int unsigned WORD_W    = 32;
	// wide enough for any cell index up to 1023
	localparam int unsigned POS_W     = 10;
	localparam int unsigned TAP_GROUP = 8;

	typedef enum logic [2:0] {
		KIND_APPEND = 3'd0,
		KIND_INSERT = 3'd1,
		KIND_REMOVE = 3'd2,
		KIND_WRITE  = 3'd3,
		KIND_READ   = 3'd4,
		KIND_CLEAR  = 3'd5
	} kind_t;

	typedef enum logic [1:0] {
		CM_HOLD   = 2'd0,
		CM_INSERT = 2'd1,
		CM_REMOVE = 2'd2,
		CM_WRITE  = 2'd3
	} cell_mode_t;

	typedef struct packed {
		cell_mode_t         mode;
		logic               rd_en;
		logic [POS_W-1:0]   pos;
		logic [WORD_W-1:0]  word;
	} cell_cmd_t;

endpackage

>>> design/ils_cell.sv
// ----------------------------------------------------------------------------
// ils_cell: one storage cell of the list row
// Holds one word; takes from its lower or upper neighbor on shifts.
// ----------------------------------------------------------------------------
module ils_cell #(
	parameter int unsigned IDX = 0
) (
	input  logic                       clk,
	input  ils_pkg::cell_cmd_t         cmd,
	input  logic [ils_pkg::WORD_W-1:0] from_lower,
	input  logic [ils_pkg::WORD_W-1:0] from_upper,
	output logic [ils_pkg::WORD_W-1:0] word_out,
	output logic [ils_pkg::WORD_W-1:0] tap
);
	import ils_pkg::*;

	localparam logic [POS_W-1:0] MY = POS_W'(IDX);

	logic [WORD_W-1:0] word_q;

	always_ff @(posedge clk) begin
		case (cmd.mode)
			CM_INSERT: begin
				if (MY > cmd.pos) begin
					word_q <= from_lower;
				end else if (MY == cmd.pos) begin
					word_q <= cmd.word;
				end
			end
			CM_REMOVE: begin
				if (MY >= cmd.pos) begin
					word_q <= from_upper;
				end
			end
			CM_WRITE: begin
				if (MY == cmd.pos) begin
					word_q <= cmd.word;
				end
			end
			default: begin
			end
		endcase
	end

	assign word_out = word_q;
	// old value, taken before this cycle's update
	assign tap = (cmd.rd_en && MY == cmd.pos) ? word_q : '0;

endmodule

>>> design/ils_collect.sv
// ----------------------------------------------------------------------------
// ils_collect: gathers the selected cell word
// Taps are ORed in registered groups, then the groups are ORed.
// ----------------------------------------------------------------------------
module ils_collect #(
	parameter int unsigned DEPTH = 64
) (
	input  logic                       clk,
	input  logic                       en,
	input  logic [ils_pkg::WORD_W-1:0] taps [DEPTH],
	output logic [ils_pkg::WORD_W-1:0] sel_word
);
	import ils_pkg::*;

	localparam int unsigned NG = (DEPTH + TAP_GROUP - 1) / TAP_GROUP;

	logic [WORD_W-1:0] pad   [NG*TAP_GROUP];
	logic [WORD_W-1:0] grp_d [NG];
	logic [WORD_W-1:0] grp_s2 [NG];

	for (genvar i = 0; i < NG*TAP_GROUP; i++) begin : g_pad
		if (i < DEPTH) begin : g_tap
			assign pad[i] = taps[i];
		end else begin : g_zero
			assign pad[i] = '0;
		end
	end

	always_comb begin
		for (int g = 0; g < NG; g++) begin
			grp_d[g] = '0;
			for (int m = 0; m < TAP_GROUP; m++) begin
				grp_d[g] = grp_d[g] | pad[g*TAP_GROUP + m];
			end
		end
	end

	// groups hold while the result waits for the output register
	always_ff @(posedge clk) begin
		if (en) begin
			grp_s2 <= grp_d;
		end
	end

	always_comb begin
		sel_word = '0;
		for (int g = 0; g < NG; g++) begin
			sel_word = sel_word | grp_s2[g];
		end
	end

endmodule

>>> design/indexed_list_store.sv
// ----------------------------------------------------------------------------
// indexed_list_store: ordered list of signed words with insert and remove
// Row of cells that shift in parallel, plus an entry count.
// ----------------------------------------------------------------------------
// One request is worked at a time. After acceptance the cell row applies the
// operation while the selected cell word is caught in the grouped tap
// registers; then, once the output register is free or being read, the groups
// are merged into the output register. A new request is accepted only after
// the previous result has entered the output register, so the block does not
// take a new request before it is through with the last one. Out-of-range
// positions, unused kinds and an append or insert on a full store give ok low
// and leave the list unchanged.
module indexed_list_store #(
	parameter int unsigned DEPTH = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [2:0]         kind,
	input  logic [6:0]         position,
	input  logic signed [31:0] word,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               ok,
	output logic signed [31:0] read_word,
	output logic [6:0]         entry_count
);
	import ils_pkg::*;

	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned WW = (CW > 7) ? CW : 7;

	logic              v_s1, v_s2, out_valid_q;
	logic [2:0]        kind_s1;
	logic [6:0]        pos_s1;
	logic [WORD_W-1:0] word_s1;
	logic [CW-1:0]     count_q, count_d;
	logic              ok_d, ok_s2;
	logic [6:0]        cnt_s2;
	logic              ok_q;
	logic [WORD_W-1:0] read_word_q;
	logic [6:0]        entry_count_q;
	cell_cmd_t         cmd;
	logic [WW-1:0]     cnt_w, pos_w;
	logic              full;

	logic [WORD_W-1:0] cell_word [DEPTH];
	logic [WORD_W-1:0] taps      [DEPTH];
	logic [WORD_W-1:0] sel_word;

	wire accept  = in_valid && in_ready;
	wire advance = v_s2 && (!out_valid_q || out_ready);

	assign in_ready = !v_s1 && !v_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
			count_q     <= '0;
		end else begin
			v_s1 <= accept;
			if (v_s1) begin
				v_s2    <= 1'b1;
				count_q <= count_d;
			end else if (advance) begin
				v_s2 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1 <= kind;
			pos_s1  <= position;
			word_s1 <= word;
		end
		if (v_s1) begin
			ok_s2  <= ok_d;
			cnt_s2 <= 7'(count_d);
		end
		if (advance) begin
			ok_q          <= ok_s2;
			read_word_q   <= sel_word;
			entry_count_q <= cnt_s2;
		end
	end

	// decode the request into a broadcast command for the row
	assign cnt_w = WW'(count_q);
	assign pos_w = WW'(pos_s1);
	assign full  = (count_q == CW'(DEPTH));

	always_comb begin
		cmd.mode  = CM_HOLD;
		cmd.rd_en = 1'b0;
		cmd.pos   = POS_W'(pos_s1);
		cmd.word  = word_s1;
		ok_d      = 1'b0;
		count_d   = count_q;
		case (kind_t'(kind_s1))
			KIND_APPEND: begin
				if (!full) begin
					cmd.mode = CM_INSERT;
					cmd.pos  = POS_W'(count_q);
					ok_d     = 1'b1;
					count_d  = count_q + 1'b1;
				end
			end
			KIND_INSERT: begin
				if (!full && pos_w <= cnt_w) begin
					cmd.mode = CM_INSERT;
					ok_d     = 1'b1;
					count_d  = count_q + 1'b1;
				end
			end
			KIND_REMOVE: begin
				if (pos_w < cnt_w) begin
					cmd.mode  = CM_REMOVE;
					cmd.rd_en = 1'b1;
					ok_d      = 1'b1;
					count_d   = count_q - 1'b1;
				end
			end
			KIND_WRITE: begin
				if (pos_w < cnt_w) begin
					cmd.mode = CM_WRITE;
					ok_d     = 1'b1;
				end
			end
			KIND_READ: begin
				if (pos_w < cnt_w) begin
					cmd.rd_en = 1'b1;
					ok_d      = 1'b1;
				end
			end
			KIND_CLEAR: begin
				ok_d    = 1'b1;
				count_d = '0;
			end
			default: begin
			end
		endcase
		if (!v_s1) begin
			cmd.mode  = CM_HOLD;
			cmd.rd_en = 1'b0;
		end
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [WORD_W-1:0] lower, upper;
		if (i == 0) begin : g_lo
			assign lower = '0;
		end else begin : g_lo
			assign lower = cell_word[i-1];
		end
		if (i == DEPTH - 1) begin : g_up
			assign upper = cell_word[i];
		end else begin : g_up
			assign upper = cell_word[i+1];
		end
		ils_cell #(.IDX(i)) u_cell (
			.clk        (clk),
			.cmd        (cmd),
			.from_lower (lower),
			.from_upper (upper),
			.word_out   (cell_word[i]),
			.tap        (taps[i])
		);
	end

	ils_collect #(.DEPTH(DEPTH)) u_collect (
		.clk      (clk),
		.en       (v_s1),
		.taps     (taps),
		.sel_word (sel_word)
	);

	assign out_valid   = out_valid_q;
	assign ok          = ok_q;
	assign read_word   = read_word_q;
	assign entry_count = entry_count_q;

endmodule

>>> design/ils_checker.sv
// ----------------------------------------------------------------------------
// ils_checker: port-level checks for the indexed list store
// Watches the request and result channels; bound to the top level.
// ----------------------------------------------------------------------------
module ils_checker #(
	parameter int unsigned DEPTH = 64
) (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic [2:0]         kind,
	input logic [6:0]         position,
	input logic signed [31:0] word,
	input logic               out_valid,
	input logic               out_ready,
	input logic               ok,
	input logic signed [31:0] read_word,
	input logic [6:0]         entry_count
);

	// one request in flight: no back-to-back acceptance
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request accepted while another is in flight");

	// a failed request never returns data
	a_fail_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !ok |-> read_word == 0)
		else $error("nonzero read_word on failed request");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (DEPTH > 127) || (entry_count <= DEPTH))
		else $error("entry_count above store depth");

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(read_word)
			&& $stable(ok) && $stable(entry_count))
		else $error("stalled result changed");

endmodule

bind indexed_list_store ils_checker #(.DEPTH(DEPTH)) u_ils_checker (.*);

>>> sim/indexed_list_store_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// indexed_list_store_tb: self-checking bench for the indexed list store
// Random and directed list requests with random stalls on both sides; each
// result is checked against a shadow copy of the list kept in the bench.
// ----------------------------------------------------------------------------
module indexed_list_store_tb;

	import ils_pkg::*;

	localparam int LIST_DEPTH    = 64;
	localparam int RANDOM_ITEMS  = 2000;
	localparam logic [2:0] KIND_SPARE_LO = 3'd6;
	localparam logic [2:0] KIND_SPARE_HI = 3'd7;

	typedef struct {
		logic [2:0]         op;
		logic [6:0]         pos;
		logic signed [31:0] value;
		bit                 drain;
	} list_request_t;

	typedef struct {
		logic               ok;
		logic signed [31:0] read_word;
		logic [6:0]         entry_count;
	} list_result_t;

	logic               clk         = 1'b0;
	logic               arst_n      = 1'b0;
	logic               in_valid    = 1'b0;
	logic               in_ready;
	logic [2:0]         kind        = '0;
	logic [6:0]         position    = '0;
	logic signed [31:0] word        = '0;
	logic               out_valid;
	logic               out_ready   = 1'b0;
	logic               ok;
	logic signed [31:0] read_word;
	logic [6:0]         entry_count;

	list_request_t pending_requests[$];
	list_result_t  expected_results[$];

	// shadow of the list contents, updated as each request is accepted
	logic signed [31:0] shadow_words[LIST_DEPTH];
	int                 shadow_len = 0;

	int error_count  = 0;
	int sent_count   = 0;
	int result_count = 0;
	int hold_left    = 0;
	int gen_len      = 0;

	indexed_list_store #(
		.DEPTH(LIST_DEPTH)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.kind       (kind),
		.position   (position),
		.word       (word),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.ok         (ok),
		.read_word  (read_word),
		.entry_count(entry_count)
	);

	always #5 clk = ~clk;

	function automatic list_result_t predict_list_op(logic [2:0] op, logic [6:0] pos,
			logic signed [31:0] value);
		list_result_t r;
		int           p;
		int           i;
		r.ok = 1'b0;
		r.read_word = '0;
		p = int'(pos);
		case (op)
			KIND_APPEND: begin
				if (shadow_len < LIST_DEPTH) begin
					shadow_words[shadow_len] = value;
					shadow_len++;
					r.ok = 1'b1;
				end
			end
			KIND_INSERT: begin
				if (p <= shadow_len && shadow_len < LIST_DEPTH) begin
					for (i = shadow_len; i > p; i--)
						shadow_words[i] = shadow_words[i - 1];
					shadow_words[p] = value;
					shadow_len++;
					r.ok = 1'b1;
				end
			end
			KIND_REMOVE: begin
				if (p < shadow_len) begin
					r.read_word = shadow_words[p];
					for (i = p; i + 1 < shadow_len; i++)
						shadow_words[i] = shadow_words[i + 1];
					shadow_len--;
					r.ok = 1'b1;
				end
			end
			KIND_WRITE: begin
				if (p < shadow_len) begin
					shadow_words[p] = value;
					r.ok = 1'b1;
				end
			end
			KIND_READ: begin
				if (p < shadow_len) begin
					r.read_word = shadow_words[p];
					r.ok = 1'b1;
				end
			end
			KIND_CLEAR: begin
				shadow_len = 0;
				r.ok = 1'b1;
			end
			default: ;
		endcase
		r.entry_count = shadow_len[6:0];
		return r;
	endfunction

	// list length after a request; lets the generator aim positions at live entries
	function automatic int len_after(logic [2:0] op, int pos, int n);
		case (op)
			KIND_APPEND: return (n < LIST_DEPTH) ? n + 1 : n;
			KIND_INSERT: return (pos <= n && n < LIST_DEPTH) ? n + 1 : n;
			KIND_REMOVE: return (pos < n) ? n - 1 : n;
			KIND_CLEAR:  return 0;
			default:     return n;
		endcase
	endfunction

	task automatic queue_request(logic [2:0] op, int pos, logic signed [31:0] value);
		list_request_t r;
		r.op = op;
		r.pos = pos[6:0];
		r.value = value;
		r.drain = 1'b0;
		pending_requests.push_back(r);
		gen_len = len_after(op, pos, gen_len);
	endtask

	task automatic queue_drain();
		list_request_t r;
		r.op = KIND_READ;
		r.pos = '0;
		r.value = '0;
		r.drain = 1'b1;
		pending_requests.push_back(r);
	endtask

	function automatic int pick_position(logic [2:0] op, int n);
		int roll;
		roll = $urandom_range(99);
		if (roll < 70) begin
			if (op == KIND_INSERT)
				return $urandom_range(n);
			return (n > 0) ? $urandom_range(n - 1) : 0;
		end
		if (roll < 85) begin
			case ($urandom_range(2))
				0:       return 0;
				1:       return n;
				default: return (n > 0) ? n - 1 : 0;
			endcase
		end
		return $urandom_range(127);
	endfunction

	function automatic logic signed [31:0] pick_word();
		case ($urandom_range(19))
			0:       return 32'sh8000_0000;
			1:       return 32'sh7fff_ffff;
			2:       return '0;
			3:       return -32'sd1;
			default: return $urandom;
		endcase
	endfunction

	// stimulus
	initial begin
		int          n;
		int          j;
		int          phase;
		int          phase_len;
		int          roll;
		logic [2:0]  op;

		// directed: empty list, both word extremes, insert at front and at the
		// end, out-of-range positions, overwrite, read, remove, spare kinds, clear
		queue_request(KIND_READ, 0, 32'sd0);
		queue_request(KIND_REMOVE, 0, 32'sd0);
		queue_request(KIND_WRITE, 0, 32'sh1234_5678);
		queue_request(KIND_APPEND, 0, 32'sh7fff_ffff);
		queue_request(KIND_APPEND, 0, 32'sh8000_0000);
		queue_request(KIND_INSERT, 0, -32'sd1);
		queue_request(KIND_INSERT, 3, 32'sd0);
		queue_request(KIND_INSERT, 5, 32'sh0bad_cafe);
		queue_request(KIND_READ, 0, 32'sd0);
		queue_request(KIND_READ, 1, 32'sd0);
		queue_request(KIND_READ, 3, 32'sd0);
		queue_request(KIND_READ, 4, 32'sd0);
		queue_request(KIND_WRITE, 1, 32'sh5a5a_5a5a);
		queue_request(KIND_READ, 1, 32'sd0);
		queue_request(KIND_REMOVE, 0, 32'sd0);
		queue_request(KIND_REMOVE, 2, 32'sd0);
		queue_request(KIND_READ, 127, 32'sd0);
		queue_request(KIND_INSERT, 127, 32'sh7fff_ffff);
		queue_request(KIND_READ, 64, 32'sd0);
		queue_request(KIND_SPARE_LO, 0, 32'sh1111_1111);
		queue_request(KIND_SPARE_HI, 1, 32'sh2222_2222);
		queue_request(KIND_CLEAR, 0, 32'sd0);
		queue_request(KIND_READ, 0, 32'sd0);
		queue_drain();

		// random: phases that grow the list to full, shrink it, or mix
		n = 0;
		while (n < RANDOM_ITEMS) begin
			phase = $urandom_range(3);
			phase_len = $urandom_range(20, 120);
			for (j = 0; j < phase_len && n < RANDOM_ITEMS; j++) begin
				roll = $urandom_range(99);
				case (phase)
					0: op = (roll < 50) ? KIND_APPEND : (roll < 80) ? KIND_INSERT :
						(roll < 88) ? KIND_READ : (roll < 94) ? KIND_WRITE : KIND_REMOVE;
					1: op = (roll < 55) ? KIND_REMOVE : (roll < 70) ? KIND_READ :
						(roll < 80) ? KIND_WRITE : (roll < 90) ? KIND_INSERT : KIND_APPEND;
					2: op = (roll < 20) ? KIND_APPEND : (roll < 40) ? KIND_INSERT :
						(roll < 60) ? KIND_REMOVE : (roll < 80) ? KIND_WRITE : KIND_READ;
					default: op = 3'($urandom_range(7));
				endcase
				roll = $urandom_range(199);
				if (roll == 0)
					op = KIND_CLEAR;
				else if (roll < 4)
					op = roll[0] ? KIND_SPARE_LO : KIND_SPARE_HI;
				queue_request(op, pick_position(op, gen_len), pick_word());
				n++;
			end
			if ($urandom_range(9) == 0)
				queue_drain();
		end

		repeat (3) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (pending_requests.size() > 0 || in_valid || expected_results.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		if (error_count == 0 && expected_results.size() == 0)
			$display("** indexed_list_store: PASSED **");
		else
			$display("** indexed_list_store: FAILED **");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("** indexed_list_store: FAILED **");
		$finish;
	end

	// request driver
	logic          slot_free;
	logic          next_valid;
	list_request_t next_req;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			kind <= KIND_APPEND;
			position <= '0;
			word <= '0;
		end else begin
			slot_free = !in_valid;
			if (in_valid && in_ready) begin
				expected_results.push_back(predict_list_op(kind, position, word));
				sent_count++;
				slot_free = 1'b1;
			end
			next_valid = !slot_free;
			if (slot_free && pending_requests.size() > 0) begin
				if (pending_requests[0].drain) begin
					// hold off until every outstanding result is back
					if (expected_results.size() == 0)
						void'(pending_requests.pop_front());
				end else if ((sent_count >= 1100 && sent_count < 1400) ||
						$urandom_range(99) >= 23) begin
					next_req = pending_requests.pop_front();
					kind <= next_req.op;
					position <= next_req.pos;
					word <= next_req.value;
					next_valid = 1'b1;
				end
			end
			in_valid <= next_valid;
		end
	end

	// result monitor
	list_result_t want;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result ok=%0b read_word=%0d entry_count=%0d",
						$time, ok, read_word, entry_count);
					error_count++;
				end else begin
					want = expected_results.pop_front();
					if (ok !== want.ok) begin
						$display("%0t: ok mismatch, expected %0b, got %0b",
							$time, want.ok, ok);
						error_count++;
					end
					if (read_word !== want.read_word) begin
						$display("%0t: read_word mismatch, expected %0d, got %0d",
							$time, want.read_word, read_word);
						error_count++;
					end
					if (entry_count !== want.entry_count) begin
						$display("%0t: entry_count mismatch, expected %0d, got %0d",
							$time, want.entry_count, entry_count);
						error_count++;
					end
				end
				result_count++;
				// long back-pressure so the input side stalls
				if (result_count == 700)
					hold_left = 400;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (result_count >= 1100 && result_count < 1400) begin
				out_ready <= 1'b1;
			end else begin
				out_ready <= ($urandom_range(99) >= 23);
			end
		end
	end

endmodule
